### sv/uslp_pkg.sv
// ----------------------------------------------------------------------------
// uslp_pkg
// Types, codes and constants shared by the USLP primary header parser.
// ----------------------------------------------------------------------------
package uslp_pkg;

    localparam int HDR_OCTETS = 7;
    localparam int HDR_BITS   = 56;

    // configuration register indexes
    localparam logic CFG_EXPECTED_VERSION = 1'b0;
    localparam logic CFG_MIN_FRAME_LENGTH = 1'b1;

    // result status codes
    localparam logic [1:0] ST_SUCCESS   = 2'd0;
    localparam logic [1:0] ST_TOO_SMALL = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;

    localparam logic [3:0] EXPECTED_VERSION_RESET = 4'd12;
    localparam logic [15:0] MIN_FRAME_LENGTH_RESET = 16'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  version;
        logic [15:0] spacecraft_id;
        logic [5:0]  virtual_channel;
        logic [3:0]  map_number;
        logic [4:0]  flag_bits;
        logic [15:0] frame_length_field;
        logic [2:0]  count_length;
        logic [55:0] frame_count;
        logic [3:0]  bytes_consumed;
    } t_out_item;

    // event from the octet accumulator for one accepted item
    typedef struct packed {
        logic                done;
        logic                too_short;
        logic [HDR_BITS-1:0] hdr;
        logic [HDR_BITS-1:0] cnt;
    } t_acc_evt;

endpackage

### sv/uslp_primary_header_parser_core.sv
// ----------------------------------------------------------------------------
// uslp_primary_header_parser_core
// USLP transfer frame primary header parser, one octet per item.
// ----------------------------------------------------------------------------
// a result is registered in the result register, or in the skid entry if the output stalls
// throughput: one octet per cycle while the input is not stalled; the header fields
//   are decoded in the same cycle the octet enters, then held in a result register with one skid entry
// input stalls only while both result register and skid entry are occupied
// reset: synchronous active low, clears position, skip state and results,
//   config returns to version 12 and minimum frame length 0
module uslp_primary_header_parser_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  uslp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output uslp_pkg::t_out_item o_out_item
);

    logic [3:0]          r_exp_ver;
    logic [15:0]         r_min_len;
    logic                w_accept;
    uslp_pkg::t_acc_evt  w_evt;
    logic                w_res_valid;
    uslp_pkg::t_out_item w_res;
    logic                w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver <= uslp_pkg::EXPECTED_VERSION_RESET;
            r_min_len <= uslp_pkg::MIN_FRAME_LENGTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                uslp_pkg::CFG_EXPECTED_VERSION: r_exp_ver <= i_cfg_data[3:0];
                uslp_pkg::CFG_MIN_FRAME_LENGTH: r_min_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    uslp_hdr_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .o_evt    (w_evt)
    );

    uslp_hdr_decode u_decode (
        .i_evt              (w_evt),
        .i_expected_version (r_exp_ver),
        .i_min_frame_length (r_min_len),
        .o_valid            (w_res_valid),
        .o_item             (w_res)
    );

    uslp_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_res_valid),
        .i_item      (w_res),
        .i_out_stall (i_out_stall),
        .o_full      (w_full),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // skid entry is only ever occupied behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> o_out_valid)
        else $error("skid entry occupied with empty result register");

    // a successful header reports the full header plus count octets
    a_success_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == uslp_pkg::ST_SUCCESS) |->
        (o_out_item.bytes_consumed == 4'd7 + {1'b0, o_out_item.count_length}))
        else $error("success result with wrong consumed count");

    // a short buffer reports nothing but its status
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == uslp_pkg::ST_TOO_SMALL) |->
        (o_out_item.bytes_consumed == 4'd0 && o_out_item.frame_count == 56'd0
         && o_out_item.version == 4'd0))
        else $error("too-small result carries field data");

    // the header and its count never complete and run short in the same item
    a_evt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_evt.done && w_evt.too_short))
        else $error("done and too-small at once");

endmodule

### sv/uslp_hdr_accum.sv
// ----------------------------------------------------------------------------
// uslp_hdr_accum
// Shifts header and count octets, tracks position and trailing-octet skip.
// ----------------------------------------------------------------------------
module uslp_hdr_accum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  uslp_pkg::t_in_item i_item,
    output uslp_pkg::t_acc_evt o_evt
);

    logic [55:0] r_hdr, n_hdr;
    logic [55:0] r_cnt, n_cnt;
    logic [3:0]  r_idx, n_idx;
    logic        r_skip, n_skip;
    logic [3:0]  w_idx_inc;
    logic [55:0] w_hdr, w_cnt;
    logic        w_done, w_short;

    assign w_idx_inc = r_idx + 4'd1;

    always_comb begin
        w_hdr   = r_hdr;
        w_cnt   = r_cnt;
        w_done  = 1'b0;
        w_short = 1'b0;
        n_hdr   = r_hdr;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_skip  = r_skip;
        if (r_skip) begin
            if (i_item.last_byte) begin
                n_skip = 1'b0;
                n_hdr  = '0;
                n_cnt  = '0;
                n_idx  = '0;
            end
        end else begin
            if (r_idx < 4'(uslp_pkg::HDR_OCTETS)) begin
                w_hdr  = {r_hdr[47:0], i_item.data_byte};
                w_done = (w_idx_inc == 4'(uslp_pkg::HDR_OCTETS)) && (w_hdr[2:0] == 3'd0);
            end else begin
                w_cnt  = {r_cnt[47:0], i_item.data_byte};
                w_done = w_idx_inc >= (4'(uslp_pkg::HDR_OCTETS) + {1'b0, r_hdr[2:0]});
            end
            n_hdr = w_hdr;
            n_cnt = w_cnt;
            n_idx = w_idx_inc;
            if (w_done || i_item.last_byte) begin
                // buffer ended or header complete: start over
                w_short = !w_done;
                n_hdr   = '0;
                n_cnt   = '0;
                n_idx   = '0;
                n_skip  = w_done && !i_item.last_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr  <= '0;
            r_cnt  <= '0;
            r_idx  <= '0;
            r_skip <= 1'b0;
        end else if (i_accept) begin
            r_hdr  <= n_hdr;
            r_cnt  <= n_cnt;
            r_idx  <= n_idx;
            r_skip <= n_skip;
        end
    end

    assign o_evt.done      = i_accept && w_done;
    assign o_evt.too_short = i_accept && w_short;
    assign o_evt.hdr       = w_hdr;
    assign o_evt.cnt       = w_cnt;

endmodule

### sv/uslp_hdr_decode.sv
// ----------------------------------------------------------------------------
// uslp_hdr_decode
// Splits the primary header into fields, checks them and builds the result.
// ----------------------------------------------------------------------------
module uslp_hdr_decode (
    input  uslp_pkg::t_acc_evt  i_evt,
    input  logic [3:0]          i_expected_version,
    input  logic [15:0]         i_min_frame_length,
    output logic                o_valid,
    output uslp_pkg::t_out_item o_item
);

    logic [55:0] w_h;
    logic        w_bad;

    assign w_h   = i_evt.hdr;
    assign w_bad = (w_h[55:52] != i_expected_version) || (w_h[23:8] < i_min_frame_length);

    always_comb begin
        o_item = '0;
        if (i_evt.done) begin
            o_item.status             = w_bad ? uslp_pkg::ST_INVALID : uslp_pkg::ST_SUCCESS;
            o_item.version            = w_h[55:52];
            o_item.spacecraft_id      = w_h[51:36];
            o_item.virtual_channel    = w_h[34:29];
            o_item.map_number         = w_h[28:25];
            // ocf, command, bypass, end-of-header, source/dest (msb first)
            o_item.flag_bits          = {w_h[3], w_h[6], w_h[7], w_h[24], w_h[35]};
            o_item.frame_length_field = w_h[23:8];
            o_item.count_length       = w_h[2:0];
            o_item.frame_count        = i_evt.cnt;
            o_item.bytes_consumed     = w_bad ? 4'd0
                                              : 4'(uslp_pkg::HDR_OCTETS) + {1'b0, w_h[2:0]};
        end else begin
            o_item.status = uslp_pkg::ST_TOO_SMALL;
        end
    end

    assign o_valid = i_evt.done || i_evt.too_short;

endmodule

### sv/uslp_out_skid.sv
// ----------------------------------------------------------------------------
// uslp_out_skid
// Result register with one skid entry so input keeps flowing while one stalled result is held.
// ----------------------------------------------------------------------------
module uslp_out_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  uslp_pkg::t_out_item i_item,
    input  logic                i_out_stall,
    output logic                o_full,
    output logic                o_out_valid,
    output uslp_pkg::t_out_item o_out_item
);

    logic                r_out_v, r_skid_v;
    uslp_pkg::t_out_item r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_out_stall) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_v || !i_out_stall) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (!i_out_stall) begin
                r_out <= r_skid;
            end
        end else if (i_valid) begin
            if (!r_out_v || !i_out_stall) begin
                r_out <= i_item;
            end else begin
                r_skid <= i_item;
            end
        end
    end

    assign o_full      = r_skid_v;
    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule
